// ===== hdl/sorted_multiset_table_assert.svh =====
// Assertion macros for the sorted multiset table.
// Included by the modules that check their own logic; uses their clock and reset ports.
`ifndef SORTED_MULTISET_TABLE_ASSERT_SVH
`define SORTED_MULTISET_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// property that must hold at every clock outside reset
`define SMT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("sorted_multiset_table: assertion failed");
// antecedent in this cycle implies consequent in the next
`define SMT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_multiset_table: assertion failed");
`else
`define SMT_ASSERT(lbl, prop)
`define SMT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/smt_pkg.sv =====
// Shared types and constants of the sorted multiset table.
// No dependencies; imported by smt_ctrl, smt_dpath and sorted_multiset_table.
package smt_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int POS_W  = 4;
   localparam int OCC_W  = 5;

   // request operation codes
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_DUMP   = 2'd2,
      OP_CLEAR  = 2'd3
   } req_kind_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_REMOVED  = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_ELEMENT  = 3'd4,
      ST_EMPTY    = 3'd5,
      ST_CLEARED  = 3'd6
   } status_code_type;

   typedef struct packed {
      req_kind_type              req_type;
      logic signed [DATA_W-1:0]  data_value;
   } req_word_type;

   typedef struct packed {
      status_code_type           status;
      logic signed [DATA_W-1:0]  item_value;
      logic [POS_W-1:0]          position;
      logic [OCC_W-1:0]          occupancy;
      logic                      last;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic exec;
      logic dump_next;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_last;
   } dp_status_type;

endpackage

// ===== hdl/smt_dpath.sv =====
// Datapath of the sorted multiset table: request latch, sorted cells, count, result word.
// Depends on smt_pkg and sorted_multiset_table_assert.svh.
`include "sorted_multiset_table_assert.svh"

module smt_dpath
   import smt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctl_cmd_type   cmd,
   input  req_word_type  req_data,
   output dp_status_type status,
   output rsp_word_type  rsp_data
);

   req_word_type             req_ff;
   logic signed [DATA_W-1:0] entries_ff [DEPTH];
   logic signed [DATA_W-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   rsp_word_type             rsp_ff, rsp_in;

   logic [DEPTH-1:0] in_use, lt_vec, eq_vec, at_or_after, seen_vec;
   logic             full, found;
   logic [IDX_W-1:0] rd_idx;
   logic             rd_last;

   // per-cell compares against the latched value
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         in_use[i]      = (CNT_W'(i) < count_ff);
         lt_vec[i]      = in_use[i] && ($signed(req_ff.data_value) < $signed(entries_ff[i]));
         eq_vec[i]      = in_use[i] && (req_ff.data_value == entries_ff[i]);
         // cell lies at or past the insert slot
         at_or_after[i] = !in_use[i] || lt_vec[i];
      end
   end

   // cells at or after the first equal entry
   for (genvar g = 0; g < DEPTH; g++) begin : g_seen
      assign seen_vec[g] = |eq_vec[g:0];
   end

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign found = |eq_vec;

   // dump read port: first entry on execute, then the next one per taken word
   assign rd_idx  = cmd.exec ? '0 : idx_ff + IDX_W'(1);
   assign rd_last = ((CNT_W'(rd_idx) + CNT_W'(1)) == count_ff);

   // next cell contents: parallel shift up on insert, down on remove
   always_comb begin
      entries_in = entries_ff;
      if (cmd.exec && req_ff.req_type == OP_INSERT && !full) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (at_or_after[i]) begin
               if (i == 0) begin
                  entries_in[i] = req_ff.data_value;
               end else if (!at_or_after[i-1]) begin
                  entries_in[i] = req_ff.data_value;
               end else begin
                  entries_in[i] = entries_ff[i-1];
               end
            end
         end
      end else if (cmd.exec && req_ff.req_type == OP_REMOVE) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (seen_vec[i]) begin
               entries_in[i] = entries_ff[i+1];
            end
         end
      end
   end

   // count and result word
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      rsp_in   = rsp_ff;
      if (cmd.exec) begin
         rsp_in.item_value = '0;
         rsp_in.position   = '0;
         rsp_in.last       = 1'b1;
         unique case (req_ff.req_type)
            OP_INSERT: begin
               if (full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  rsp_in.status = ST_INSERTED;
                  count_in      = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (found) begin
                  rsp_in.status = ST_REMOVED;
                  count_in      = count_ff - CNT_W'(1);
               end else begin
                  rsp_in.status = ST_NOTFOUND;
               end
            end
            OP_DUMP: begin
               idx_in = rd_idx;
               if (count_ff == '0) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  rsp_in.status     = ST_ELEMENT;
                  rsp_in.item_value = entries_ff[rd_idx];
                  rsp_in.last       = rd_last;
               end
            end
            OP_CLEAR: begin
               rsp_in.status = ST_CLEARED;
               count_in      = '0;
            end
            default: begin
               rsp_in.status = ST_CLEARED;
            end
         endcase
         rsp_in.occupancy = OCC_W'(count_in);
      end else if (cmd.dump_next) begin
         idx_in            = rd_idx;
         rsp_in.status     = ST_ELEMENT;
         rsp_in.item_value = entries_ff[rd_idx];
         rsp_in.position   = POS_W'(rd_idx);
         rsp_in.last       = rd_last;
         rsp_in.occupancy  = OCC_W'(count_ff);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      entries_ff <= entries_in;
      idx_ff     <= idx_in;
      rsp_ff     <= rsp_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_data        = rsp_ff;
   assign status.rsp_last = rsp_ff.last;

   `SMT_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH))
   `SMT_ASSERT_NEXT(a_clear_empties, cmd.exec && req_ff.req_type == OP_CLEAR, count_ff == '0)

endmodule

// ===== hdl/smt_ctrl.sv =====
// Controller of the sorted multiset table: sequences accept, execute and result words.
// Depends on smt_pkg and sorted_multiset_table_assert.svh.
`include "sorted_multiset_table_assert.svh"

module smt_ctrl
   import smt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SEND
   } state_type;

   state_type state_ff, state_in;

   // commands to the datapath
   assign cmd.load_req  = (state_ff == S_IDLE) && req_valid;
   assign cmd.exec      = (state_ff == S_EXEC);
   assign cmd.dump_next = (state_ff == S_SEND) && !rsp_stall && !status.rsp_last;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_SEND);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_SEND;
         end
         S_SEND: begin
            if (!rsp_stall && status.rsp_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SMT_ASSERT_NEXT(a_accept_exec, req_valid && !req_stall, state_ff == S_EXEC)
   `SMT_ASSERT_NEXT(a_exec_send, state_ff == S_EXEC, state_ff == S_SEND)

endmodule

// ===== hdl/sorted_multiset_table.sv =====
// Top level of the sorted multiset table: controller plus datapath.
// Depends on smt_pkg, smt_ctrl and smt_dpath.
//
//   channel  | ports                               | word
//   request  | req_valid, req_stall, req_data      | req_word_type (req_type, data_value)
//   result   | rsp_valid, rsp_stall, rsp_data      | rsp_word_type (status .. last)
//
// Insert, remove and clear pass through accept, an execute step in which all
// cells compare and shift at once, and the result word.
// Dump sends one entry per cycle through the read mux, unless the result side stalls.
// Reset clears the entry count and the controller; cell contents need no reset.
// A stalled result word holds; a new request is taken only after the last word leaves.

module sorted_multiset_table
   import smt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   smt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   smt_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// ===== bench/smt_checker.sv =====
// Checker for the sorted multiset table: watches both channels, keeps its own sorted table,
// and compares every result word against the oldest predicted one. Depends on smt_pkg.
`timescale 1ns / 1ps

module smt_checker
   import smt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_data,
   output int           fail_count,
   output int           words_pending,
   output int           words_checked,
   output int           full_hits
);

   // shadow of the table contents, ascending
   logic signed [DATA_W-1:0] stored_vals [DEPTH];
   int                       stored_count = 0;
   rsp_word_type             expected_words [$];
   int                       errors  = 0;
   int                       checked = 0;
   int                       fulls   = 0;

   function automatic rsp_word_type make_word(input status_code_type st,
                                              input logic signed [DATA_W-1:0] item,
                                              input int pos, input int occ, input logic lst);
      rsp_word_type w;
      w.status     = st;
      w.item_value = item;
      w.position   = POS_W'(pos);
      w.occupancy  = OCC_W'(occ);
      w.last       = lst;
      return w;
   endfunction

   // update the shadow table for one request and queue the words it should produce
   task automatic predict_results(input req_word_type w);
      int slot;
      int i;
      slot = 0;
      case (w.req_type)
         OP_INSERT: begin
            if (stored_count >= DEPTH) begin
               expected_words.push_back(make_word(ST_FULL, '0, 0, stored_count, 1'b1));
            end else begin
               // new value goes after every entry that is not greater
               while (slot < stored_count && !(w.data_value < stored_vals[slot])) slot++;
               for (i = stored_count; i > slot; i--) stored_vals[i] = stored_vals[i-1];
               stored_vals[slot] = w.data_value;
               stored_count++;
               expected_words.push_back(make_word(ST_INSERTED, '0, 0, stored_count, 1'b1));
            end
         end
         OP_REMOVE: begin
            while (slot < stored_count && stored_vals[slot] != w.data_value) slot++;
            if (slot >= stored_count) begin
               expected_words.push_back(make_word(ST_NOTFOUND, '0, 0, stored_count, 1'b1));
            end else begin
               for (i = slot; i + 1 < stored_count; i++) stored_vals[i] = stored_vals[i+1];
               stored_count--;
               expected_words.push_back(make_word(ST_REMOVED, '0, 0, stored_count, 1'b1));
            end
         end
         OP_DUMP: begin
            if (stored_count == 0) begin
               expected_words.push_back(make_word(ST_EMPTY, '0, 0, 0, 1'b1));
            end else begin
               for (i = 0; i < stored_count; i++)
                  expected_words.push_back(make_word(ST_ELEMENT, stored_vals[i], i,
                                                     stored_count, i == stored_count - 1));
            end
         end
         default: begin
            stored_count = 0;
            expected_words.push_back(make_word(ST_CLEARED, '0, 0, 0, 1'b1));
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                              input logic [DATA_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // results are checked before the request of the same edge is predicted
   always @(posedge clock) begin : monitor
      rsp_word_type exp_w;
      if (reset) begin
         stored_count = 0;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("result word with none expected: status %0d item %0h",
                      rsp_data.status, rsp_data.item_value);
               errors++;
            end else begin
               exp_w = expected_words.pop_front();
               check_field("status",     exp_w.status,     rsp_data.status);
               check_field("item_value", exp_w.item_value, rsp_data.item_value);
               check_field("position",   exp_w.position,   rsp_data.position);
               check_field("occupancy",  exp_w.occupancy,  rsp_data.occupancy);
               check_field("last",       exp_w.last,       rsp_data.last);
               checked++;
               if (exp_w.status == ST_FULL) fulls++;
            end
         end
         if (req_valid && !req_stall) predict_results(req_data);
      end
      fail_count    <= errors;
      words_pending <= expected_words.size();
      words_checked <= checked;
      full_hits     <= fulls;
   end

endmodule

// ===== bench/tb.sv =====
// Top of the sorted multiset table bench: clock, reset, request stimulus, result stall
// and watchdog. Depends on smt_pkg, sorted_multiset_table and smt_checker.
`timescale 1ns / 1ps

module tb;
   import smt_pkg::*;

   localparam int RANDOM_ITEMS = 303;
   localparam int IDLE_LIMIT   = 5000;
   localparam int TAIL_CYCLES  = 20;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   int  fail_count;
   int  words_pending;
   int  words_checked;
   int  full_hits;
   int  idle_cycles = 0;
   int  sent_by_kind [4] = '{0, 0, 0, 0};
   logic steady = 1'b0;
   logic signed [DATA_W-1:0] value_pool [8];

   sorted_multiset_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   smt_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .words_pending (words_pending),
      .words_checked (words_checked),
      .full_hits     (full_hits)
   );

   always #5 clock = ~clock;

   // result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 12);
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one request word; returns at the edge that accepts it
   task automatic send_req(input req_kind_type kind, input logic signed [DATA_W-1:0] val);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_data.req_type   <= kind;
      req_data.data_value <= val;
      sent_by_kind[kind]++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pool_entry();
      case ($urandom_range(5))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2, 3:    return DATA_W'($urandom_range(6)) - DATA_W'(3);
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      int k;
      int r;
      int mode;
      req_kind_type kind;
      logic signed [DATA_W-1:0] val;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty cases, extremes, ties, full table
      send_req(OP_DUMP, $urandom);
      send_req(OP_REMOVE, 5);
      send_req(OP_CLEAR, $urandom);
      send_req(OP_INSERT, VAL_MAX);
      send_req(OP_INSERT, VAL_MIN);
      send_req(OP_INSERT, 0);
      send_req(OP_INSERT, -1);
      send_req(OP_INSERT, 0);
      send_req(OP_DUMP, 0);
      send_req(OP_REMOVE, 0);
      for (k = 0; k < 12; k++) send_req(OP_INSERT, (k % 3 == 0) ? VAL_MAX : $urandom);
      send_req(OP_INSERT, VAL_MAX);
      send_req(OP_DUMP, VAL_MIN);
      send_req(OP_REMOVE, VAL_MIN);
      send_req(OP_CLEAR, VAL_MAX);
      send_req(OP_DUMP, -1);

      // random: phases that lean toward filling, draining, or a mix
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 40 == 0)
            for (int j = 0; j < 8; j++) value_pool[j] = pool_entry();
         steady = (k >= 120 && k < 200);
         mode = (k / 40) % 3;
         r = $urandom_range(99);
         if (r < (mode == 0 ? 70 : mode == 1 ? 25 : 45))      kind = OP_INSERT;
         else if (r < (mode == 0 ? 90 : mode == 1 ? 85 : 80)) kind = OP_REMOVE;
         else if (r < 97)                                      kind = OP_DUMP;
         else                                                  kind = OP_CLEAR;
         val = ($urandom_range(99) < 75) ? value_pool[$urandom_range(7)] : $urandom;
         send_req(kind, val);
      end
      steady = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (words_pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Requests sent: %0d insert, %0d remove, %0d dump, %0d clear.",
               sent_by_kind[OP_INSERT], sent_by_kind[OP_REMOVE],
               sent_by_kind[OP_DUMP], sent_by_kind[OP_CLEAR]);
      $display("Result words checked: %0d, inserts refused on a full table: %0d.",
               words_checked, full_hits);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
